@@ rtl/gcm_pkg.sv @@
package gcm_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int CHANNEL_BITS  = 8;
  localparam int COLOR_BITS    = 3 * CHANNEL_BITS;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_BITS  = $clog2(NUM_REGS);
  localparam int CFG_DATA_BITS = (VALUE_BITS > COLOR_BITS) ? VALUE_BITS : COLOR_BITS;

  // signed offset and span of one segment
  localparam int SPAN_BITS = VALUE_BITS + 1;
  // signed colour difference of one channel
  localparam int DIFF_BITS = CHANNEL_BITS + 1;
  localparam int PROD_BITS = SPAN_BITS + DIFF_BITS;
  // magnitude of the product, always below 2^(value + channel bits)
  localparam int MAG_BITS  = VALUE_BITS + CHANNEL_BITS;
  // quotient magnitudes at or above 2^QUO_BITS saturate whatever the base
  localparam int QUO_BITS  = CHANNEL_BITS + 1;
  localparam int SUM_BITS  = CHANNEL_BITS + 3;

  typedef enum logic [1:0] {
    MODE_SOLID      = 2'd0,
    MODE_TWO_STOP   = 2'd1,
    MODE_THREE_STOP = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE           = 3'd0,
    REG_LOW_COLOR      = 3'd1,
    REG_MID_COLOR      = 3'd2,
    REG_HIGH_COLOR     = 3'd3,
    REG_INACTIVE_COLOR = 3'd4,
    REG_RANGE_MIN      = 3'd5,
    REG_RANGE_MAX      = 3'd6,
    REG_MIDPOINT       = 3'd7
  } cfg_reg_t;

  typedef logic [CHANNEL_BITS-1:0]       chan_t;
  typedef logic [2:0][CHANNEL_BITS-1:0]  color_t;
  typedef logic [VALUE_BITS-1:0]         value_t;

  typedef struct packed {
    mode_t  mode;
    color_t low_color;
    color_t mid_color;
    color_t high_color;
    color_t inactive_color;
    value_t range_min;
    value_t range_max;
    value_t midpoint;
  } cfg_t;

  typedef struct packed {
    color_t                       base;
    logic [2:0][DIFF_BITS-1:0]    diff;
    logic [SPAN_BITS-1:0]         off;
    logic [SPAN_BITS-1:0]         span;
    logic                         flat;
  } seg_t;

  typedef struct packed {
    color_t                       base;
    logic [2:0][PROD_BITS-1:0]    prod;
    logic [SPAN_BITS-1:0]         span;
    logic                         flat;
  } prod_t;

  typedef struct packed {
    color_t                       base;
    logic [2:0][MAG_BITS-1:0]     rem;
    logic [2:0][QUO_BITS-1:0]     quo;
    logic [2:0]                   neg;
    logic [2:0]                   big;
    value_t                       den;
    logic                         flat;
  } div_t;

endpackage

@@ rtl/gcm_if.sv @@
interface gcm_in_if import gcm_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface gcm_out_if import gcm_pkg::*; ();
  logic  valid;
  logic  ready;
  chan_t red;
  chan_t green;
  chan_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/gcm_select.sv @@
module gcm_select import gcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   up_valid,
  output logic   up_ready,
  input  value_t up_value,
  output logic   dn_valid,
  input  logic   dn_ready,
  output seg_t   dn_seg
);

  logic   v_r;
  seg_t   seg_r;
  seg_t   seg_nxt;
  color_t from_c;
  color_t to_c;
  value_t lo;
  value_t hi;

  always_comb begin
    unique case (cfg.mode)
      MODE_TWO_STOP: begin
        from_c = cfg.low_color;
        to_c   = cfg.high_color;
        lo     = cfg.range_min;
        hi     = cfg.range_max;
      end
      MODE_THREE_STOP: begin
        if (up_value > cfg.midpoint) begin
          from_c = cfg.mid_color;
          to_c   = cfg.high_color;
          lo     = cfg.midpoint;
          hi     = cfg.range_max;
        end else begin
          from_c = cfg.low_color;
          to_c   = cfg.mid_color;
          lo     = cfg.range_min;
          hi     = cfg.midpoint;
        end
      end
      default: begin
        // solid colour: an empty span makes the base colour pass through
        from_c = cfg.inactive_color;
        to_c   = cfg.inactive_color;
        lo     = '0;
        hi     = '0;
      end
    endcase

    seg_nxt.base = from_c;
    for (int i = 0; i < 3; i++) begin
      seg_nxt.diff[i] = {1'b0, to_c[i]} - {1'b0, from_c[i]};
    end
    seg_nxt.off  = {1'b0, up_value} - {1'b0, lo};
    seg_nxt.span = {1'b0, hi} - {1'b0, lo};
    seg_nxt.flat = (hi == lo);
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      seg_r <= seg_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_seg   = seg_r;

endmodule

@@ rtl/gcm_scale.sv @@
module gcm_scale import gcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  seg_t up_seg,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_div
);

  // stage a: products, stage b: magnitudes and signs, stage c: range check
  logic  va_r, vb_r, vc_r;
  logic  rdy_a, rdy_b, rdy_c;
  prod_t pa_r, pa_nxt;
  div_t  db_r, db_nxt;
  div_t  dc_r, dc_nxt;

  always_comb begin
    logic signed [PROD_BITS-1:0] p;
    pa_nxt.base = up_seg.base;
    pa_nxt.span = up_seg.span;
    pa_nxt.flat = up_seg.flat;
    for (int i = 0; i < 3; i++) begin
      p = $signed(up_seg.diff[i]) * $signed(up_seg.off);
      pa_nxt.prod[i] = p;
    end
  end

  always_comb begin
    logic                 span_neg;
    logic [SPAN_BITS-1:0] span_abs;
    logic                 p_neg;
    logic [PROD_BITS-1:0] p_abs;
    span_neg = pa_r.span[SPAN_BITS-1];
    span_abs = span_neg ? (~pa_r.span + 1'b1) : pa_r.span;
    db_nxt.base = pa_r.base;
    db_nxt.flat = pa_r.flat;
    db_nxt.den  = span_abs[VALUE_BITS-1:0];
    db_nxt.big  = '0;
    db_nxt.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      p_neg = pa_r.prod[i][PROD_BITS-1];
      p_abs = p_neg ? (~pa_r.prod[i] + 1'b1) : pa_r.prod[i];
      db_nxt.rem[i] = p_abs[MAG_BITS-1:0];
      db_nxt.neg[i] = p_neg ^ span_neg;
    end
  end

  always_comb begin
    dc_nxt = db_r;
    for (int i = 0; i < 3; i++) begin
      dc_nxt.big[i] = ({1'b0, db_r.rem[i]} >= {db_r.den, {QUO_BITS{1'b0}}});
    end
  end

  assign rdy_c    = ~vc_r | dn_ready;
  assign rdy_b    = ~vb_r | rdy_c;
  assign rdy_a    = ~va_r | rdy_b;
  assign up_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) pa_r <= pa_nxt;
    if (rdy_b && va_r)     db_r <= db_nxt;
    if (rdy_c && vb_r)     dc_r <= dc_nxt;
  end

  assign dn_valid = vc_r;
  assign dn_div   = dc_r;

endmodule

@@ rtl/gcm_div.sv @@
module gcm_div import gcm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_div,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_div
);

  // one restoring step per stage, quotient msb first
  logic v_r [QUO_BITS];
  div_t d_r [QUO_BITS];
  logic rdy [QUO_BITS+1];

  assign rdy[QUO_BITS] = dn_ready;

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int BIT = QUO_BITS - 1 - k;
    logic                v_in;
    div_t                d_in;
    div_t                d_nxt;
    logic [MAG_BITS-1:0] trial;

    if (k == 0) begin : g_first
      assign v_in = up_valid;
      assign d_in = up_div;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign d_in = d_r[k-1];
    end

    assign trial = MAG_BITS'(d_in.den) << BIT;

    always_comb begin
      d_nxt = d_in;
      for (int i = 0; i < 3; i++) begin
        if (d_in.rem[i] >= trial) begin
          d_nxt.rem[i]      = d_in.rem[i] - trial;
          d_nxt.quo[i][BIT] = 1'b1;
        end
      end
    end

    assign rdy[k] = ~v_r[k] | rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        d_r[k] <= d_nxt;
      end
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[QUO_BITS-1];
  assign dn_div   = d_r[QUO_BITS-1];

endmodule

@@ rtl/gcm_sat.sv @@
module gcm_sat import gcm_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  div_t   up_div,
  output logic   dn_valid,
  input  logic   dn_ready,
  output color_t dn_color
);

  localparam chan_t CH_MAX = '1;

  logic   v_r;
  color_t col_r;
  color_t col_nxt;

  always_comb begin
    logic signed [QUO_BITS:0]   q;
    logic signed [SUM_BITS-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      q   = up_div.neg[i] ? -$signed({1'b0, up_div.quo[i]}) : $signed({1'b0, up_div.quo[i]});
      sum = $signed({3'b000, up_div.base[i]}) + $signed({q[QUO_BITS], q});
      priority if (up_div.flat) begin
        col_nxt[i] = up_div.base[i];
      end else if (up_div.big[i]) begin
        col_nxt[i] = up_div.neg[i] ? '0 : CH_MAX;
      end else if (sum < 0) begin
        col_nxt[i] = '0;
      end else if (sum > $signed({3'b000, CH_MAX})) begin
        col_nxt[i] = CH_MAX;
      end else begin
        col_nxt[i] = sum[CHANNEL_BITS-1:0];
      end
    end
  end

  assign up_ready = ~v_r | dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      col_r <= col_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_color = col_r;

endmodule

@@ rtl/gradient_color_map.sv @@
// channel    | direction | handshake                | payload
// in_chan    | sink      | valid/ready              | value
// out_chan   | source    | valid/ready              | red, green, blue
// cfg port   | sink      | cfg_we, no back-pressure | cfg_idx, cfg_data
//
// one item per clock sustained while the output is not stalled, 14 register stages:
// segment select 1, multiply/magnitude/range check 3, one quotient bit per stage 9,
// saturation 1; the quotient stages set the depth
// every stage holds its item under stall and takes a new one when it or a later
// stage is free, so bubbles collapse and the input stays open while a result waits
// until all 14 stages hold an item
// rst_n is synchronous, clears the valid bits and loads the register defaults
module gradient_color_map import gcm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  gcm_in_if.sink                   in_chan,
  gcm_out_if.source                out_chan,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  // register defaults
  localparam chan_t  CH_HALF   = chan_t'(1) << (CHANNEL_BITS - 1);
  localparam color_t MID_RESET = {3{CH_HALF}};
  localparam value_t MP_RESET  = value_t'(1) << (VALUE_BITS - 1);

  mode_t  mode_r;
  color_t low_color_r;
  color_t mid_color_r;
  color_t high_color_r;
  color_t inactive_color_r;
  value_t range_min_r;
  value_t range_max_r;
  value_t midpoint_r;
  cfg_t   cfg;

  // handshakes between the sections
  logic   sel_valid, sel_ready;
  seg_t   sel_seg;
  logic   scl_valid, scl_ready;
  div_t   scl_div;
  logic   div_valid, div_ready;
  div_t   div_res;
  color_t out_color;

  // configuration registers; the user must write them only while no item is in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_TWO_STOP;
      low_color_r      <= '0;
      mid_color_r      <= MID_RESET;
      high_color_r     <= '1;
      inactive_color_r <= '0;
      range_min_r      <= '0;
      range_max_r      <= '1;
      midpoint_r       <= MP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_MODE:           mode_r           <= mode_t'(cfg_data[1:0]);
        REG_LOW_COLOR:      low_color_r      <= cfg_data[COLOR_BITS-1:0];
        REG_MID_COLOR:      mid_color_r      <= cfg_data[COLOR_BITS-1:0];
        REG_HIGH_COLOR:     high_color_r     <= cfg_data[COLOR_BITS-1:0];
        REG_INACTIVE_COLOR: inactive_color_r <= cfg_data[COLOR_BITS-1:0];
        REG_RANGE_MIN:      range_min_r      <= cfg_data[VALUE_BITS-1:0];
        REG_RANGE_MAX:      range_max_r      <= cfg_data[VALUE_BITS-1:0];
        REG_MIDPOINT:       midpoint_r       <= cfg_data[VALUE_BITS-1:0];
      endcase
    end
  end

  assign cfg.mode           = mode_r;
  assign cfg.low_color      = low_color_r;
  assign cfg.mid_color      = mid_color_r;
  assign cfg.high_color     = high_color_r;
  assign cfg.inactive_color = inactive_color_r;
  assign cfg.range_min      = range_min_r;
  assign cfg.range_max      = range_max_r;
  assign cfg.midpoint       = midpoint_r;

  // pick the active segment, colour differences, offset and span
  gcm_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_value (in_chan.value),
    .dn_valid (sel_valid),
    .dn_ready (sel_ready),
    .dn_seg   (sel_seg)
  );

  // products, sign-magnitude split and the saturation pre-check
  gcm_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sel_valid),
    .up_ready (sel_ready),
    .up_seg   (sel_seg),
    .dn_valid (scl_valid),
    .dn_ready (scl_ready),
    .dn_div   (scl_div)
  );

  // truncating division, one quotient bit per stage for all three channels
  gcm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (scl_valid),
    .up_ready (scl_ready),
    .up_div   (scl_div),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_div   (div_res)
  );

  // apply sign, add the base colour, clamp; this is the output register
  gcm_sat u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_div   (div_res),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_color (out_color)
  );

  assign out_chan.red   = out_color[2];
  assign out_chan.green = out_color[1];
  assign out_chan.blue  = out_color[0];

endmodule

@@ tb/sv/gradient_color_map_test.sv @@
import gcm_pkg::*;

class colour_scoreboard;
  logic [1:0] mode;
  color_t     low_color;
  color_t     mid_color;
  color_t     high_color;
  color_t     inactive_color;
  value_t     range_min;
  value_t     range_max;
  value_t     midpoint;
  color_t     expected_colours[$];
  int         errors;

  function new();
    mode           = MODE_TWO_STOP;
    low_color      = 24'h000000;
    mid_color      = 24'h808080;
    high_color     = 24'hFFFFFF;
    inactive_color = 24'h000000;
    range_min      = 16'h0000;
    range_max      = 16'hFFFF;
    midpoint       = 16'h8000;
    errors         = 0;
  endfunction

  // unused upper bits of the write data are dropped
  function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_MODE:           mode           = data[1:0];
      REG_LOW_COLOR:      low_color      = data[COLOR_BITS-1:0];
      REG_MID_COLOR:      mid_color      = data[COLOR_BITS-1:0];
      REG_HIGH_COLOR:     high_color     = data[COLOR_BITS-1:0];
      REG_INACTIVE_COLOR: inactive_color = data[COLOR_BITS-1:0];
      REG_RANGE_MIN:      range_min      = data[VALUE_BITS-1:0];
      REG_RANGE_MAX:      range_max      = data[VALUE_BITS-1:0];
      REG_MIDPOINT:       midpoint       = data[VALUE_BITS-1:0];
      default: ;
    endcase
  endfunction

  // straight line between two stops, quotient truncated toward zero, then clamped
  function color_t blend(color_t from, color_t to, value_t v, value_t lo, value_t hi);
    longint span;
    longint off;
    longint a;
    longint b;
    longint c;
    color_t res;
    span = longint'(hi) - longint'(lo);
    off  = longint'(v) - longint'(lo);
    for (int ch = 0; ch < 3; ch++) begin
      a = from[ch];
      b = to[ch];
      c = a;
      if (span != 0) c = a + ((b - a) * off) / span;
      if (c < 0) res[ch] = '0;
      else if (c > (longint'(1) << CHANNEL_BITS) - 1) res[ch] = '1;
      else res[ch] = c[CHANNEL_BITS-1:0];
    end
    return res;
  endfunction

  function color_t map_value(value_t v);
    if (mode == MODE_TWO_STOP) return blend(low_color, high_color, v, range_min, range_max);
    if (mode == MODE_THREE_STOP) begin
      if (v > midpoint) return blend(mid_color, high_color, v, midpoint, range_max);
      return blend(low_color, mid_color, v, range_min, midpoint);
    end
    return inactive_color;
  endfunction

  function void note_sample(value_t v);
    expected_colours.push_back(map_value(v));
  endfunction

  function void check_colour(chan_t r, chan_t g, chan_t b);
    color_t want;
    color_t got;
    string  chan_name[3] = '{"blue", "green", "red"};
    got = {r, g, b};
    if (expected_colours.size() == 0) begin
      errors++;
      $display("%0t: unexpected colour, expected none, actual %06h", $time, got);
      return;
    end
    want = expected_colours.pop_front();
    for (int ch = 2; ch >= 0; ch--) begin
      if (got[ch] !== want[ch]) begin
        errors++;
        $display("%0t: %s expected %02h actual %02h", $time, chan_name[ch], want[ch],
                 got[ch]);
      end
    end
  endfunction

  function int outstanding();
    return expected_colours.size();
  endfunction
endclass

module gradient_color_map_test;

  // mode code with no meaning of its own, the block treats it as solid
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // register stages from input to output, from the block's header
  localparam int PIPE_DEPTH  = 14;
  // receiver hold-off that fills the pipe and closes the input
  localparam int HOLD_CYCLES = 300;
  // cycles without any handshake before the run is abandoned
  localparam int QUIET_LIMIT = 4000;
  localparam int SETUPS      = 10;
  localparam int BURST_ITEMS = 40;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_reg_t                 cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  gcm_in_if  in_chan ();
  gcm_out_if out_chan ();

  gradient_color_map i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  colour_scoreboard sb = new();

  // idling odds in percent, changed per regime by the main sequence
  int send_idle_pct;
  int recv_idle_pct;
  // receiver hold-off: requested by the main sequence, counted down below
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  // current segment bounds, used to aim sample values at the active range
  int lo_bound;
  int hi_bound;
  int mid_bound;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random back-pressure, or a long hold-off when asked for one
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_chan.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req       = 1'b0;
      hold_left      = HOLD_CYCLES - 1;
      out_chan.ready = 1'b0;
    end else begin
      out_chan.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // handshakes are seen at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready) sb.note_sample(in_chan.value);
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_colour(out_chan.red, out_chan.green, out_chan.blue);
  end

  // watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_value(value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.value = v;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // drain every outstanding colour, then let the pipe go quiet
  task automatic settle();
    in_chan.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  // now and then junk in the bits above a register's width
  function automatic logic [CFG_DATA_BITS-1:0] upper_noise();
    return ($urandom_range(3) == 0) ? CFG_DATA_BITS'($urandom) : '0;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_colour();
    logic [CFG_DATA_BITS-1:0] d;
    d = upper_noise();
    case ($urandom_range(5))
      0:       d[COLOR_BITS-1:0] = '0;
      1:       d[COLOR_BITS-1:0] = '1;
      default: d[COLOR_BITS-1:0] = COLOR_BITS'($urandom);
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] with_value(int v);
    logic [CFG_DATA_BITS-1:0] d;
    d = upper_noise();
    d[VALUE_BITS-1:0] = VALUE_BITS'(v);
    return d;
  endfunction

  // half inside the active range with a margin either side, else extremes, random or near the midpoint
  function automatic value_t pick_value();
    int lo;
    int hi;
    int margin;
    lo     = (lo_bound < hi_bound) ? lo_bound : hi_bound;
    hi     = (lo_bound < hi_bound) ? hi_bound : lo_bound;
    margin = (hi - lo) / 8 + 4;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return value_t'($urandom);
      4:       return value_t'($urandom_range((mid_bound + 2 > 65535) ? 65535 : mid_bound + 2,
                                          (mid_bound < 2) ? 0 : mid_bound - 2));
      default: return value_t'($urandom_range((hi + margin > 65535) ? 65535 : hi + margin,
                                          (lo < margin) ? 0 : lo - margin));
    endcase
  endfunction

  // new setting for every register; called only with the pipe empty
  task automatic random_setup();
    logic [1:0]               m;
    logic [CFG_DATA_BITS-1:0] d;
    case ($urandom_range(9))
      0:          m = MODE_SOLID;
      1:          m = MODE_UNUSED;
      2, 3, 4, 5: m = MODE_TWO_STOP;
      default:    m = MODE_THREE_STOP;
    endcase
    d      = upper_noise();
    d[1:0] = m;
    program_reg(REG_MODE, d);
    program_reg(REG_LOW_COLOR, pick_colour());
    program_reg(REG_MID_COLOR, pick_colour());
    program_reg(REG_HIGH_COLOR, pick_colour());
    program_reg(REG_INACTIVE_COLOR, pick_colour());
    case ($urandom_range(4))
      0: begin
        lo_bound = $urandom_range(65535);
        hi_bound = $urandom_range(65535);
      end
      1: begin
        // short rising span
        lo_bound = $urandom_range(65535);
        hi_bound = lo_bound + $urandom_range(400);
      end
      2: begin
        lo_bound = 0;
        hi_bound = 65535;
      end
      3: begin
        // reversed span, negative divisor
        hi_bound = $urandom_range(65535);
        lo_bound = hi_bound + $urandom_range(400);
      end
      default: begin
        lo_bound = $urandom_range(65535);
        hi_bound = lo_bound;
      end
    endcase
    if (lo_bound > 65535) lo_bound = 65535;
    if (hi_bound > 65535) hi_bound = 65535;
    case ($urandom_range(5))
      0:       mid_bound = lo_bound;
      1:       mid_bound = hi_bound;
      2:       mid_bound = $urandom_range(65535);
      default: mid_bound = $urandom_range(hi_bound, lo_bound);
    endcase
    program_reg(REG_RANGE_MIN, with_value(lo_bound));
    program_reg(REG_RANGE_MAX, with_value(hi_bound));
    program_reg(REG_MIDPOINT, with_value(mid_bound));
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = REG_MODE;
    cfg_data       = '0;
    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    out_chan.ready = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    lo_bound       = 0;
    hi_bound       = 65535;
    mid_bound      = 32768;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register defaults: black to white over the full range
    send_value('0);
    send_value('1);
    send_value(16'h8000);
    settle();

    // solid colour, then the spare mode code which also gives the solid colour
    program_reg(REG_INACTIVE_COLOR, 24'hA5C3F0);
    program_reg(REG_MODE, MODE_SOLID);
    send_value(16'h04D2);
    settle();
    program_reg(REG_MODE, MODE_UNUSED);
    send_value('1);
    settle();

    // narrow two-stop range: ends, middle, and values far outside that saturate
    program_reg(REG_MODE, MODE_TWO_STOP);
    program_reg(REG_LOW_COLOR, 24'h00FF10);
    program_reg(REG_HIGH_COLOR, 24'hFF0080);
    program_reg(REG_RANGE_MIN, 16'd1000);
    program_reg(REG_RANGE_MAX, 16'd2000);
    send_value('0);
    send_value('1);
    send_value(16'd1500);
    send_value(16'd1000);
    send_value(16'd2000);
    settle();

    // zero span gives the low colour whatever the value
    program_reg(REG_RANGE_MIN, 16'd500);
    program_reg(REG_RANGE_MAX, 16'd500);
    send_value(16'd500);
    send_value('0);
    send_value('1);
    settle();

    // reversed range, divisor below zero
    program_reg(REG_RANGE_MIN, 16'd3000);
    program_reg(REG_RANGE_MAX, 16'd1000);
    send_value(16'd2000);
    send_value('0);
    send_value(16'd4000);
    settle();

    // three stops: value on the midpoint takes the lower segment
    program_reg(REG_MODE, MODE_THREE_STOP);
    program_reg(REG_LOW_COLOR, 24'h000000);
    program_reg(REG_MID_COLOR, 24'h808080);
    program_reg(REG_HIGH_COLOR, 24'hFFFFFF);
    program_reg(REG_RANGE_MIN, 16'd0);
    program_reg(REG_MIDPOINT, 16'd100);
    program_reg(REG_RANGE_MAX, 16'd200);
    send_value(16'd100);
    send_value(16'd101);
    send_value(16'd50);
    send_value(16'd200);
    send_value('1);
    settle();

    // both segments flat: lower gives the low colour, upper the mid colour
    program_reg(REG_RANGE_MIN, 16'd7);
    program_reg(REG_MIDPOINT, 16'd7);
    program_reg(REG_RANGE_MAX, 16'd7);
    send_value(16'd7);
    send_value(16'd8);
    settle();

    // random bursts: fast sender with a busy receiver, then swapped, then flat out
    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 29 : (regime == 1) ? 88 : 0;
      recv_idle_pct = (regime == 0) ? 88 : (regime == 1) ? 29 : 0;
      for (int s = 0; s < SETUPS; s++) begin
        random_setup();
        // one burst runs into a long receiver hold-off so the input backs up
        if (regime == 2 && s == SETUPS / 2) hold_req = 1'b1;
        for (int i = 0; i < BURST_ITEMS; i++) send_value(pick_value());
        settle();
      end
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
